FILE: sv/ppd_pkg.sv
package ppd_pkg;

    localparam int ID_W          = 16;
    localparam int NUM_POOL_REGS = 3;

    localparam logic [3:0] DEFAULT_POOL = 4'd2;
    localparam logic [3:0] FREE_MAX     = 4'd15;

    localparam logic [2:0] ST_DISPATCHED = 3'd0;
    localparam logic [2:0] ST_QUEUED     = 3'd1;
    localparam logic [2:0] ST_DROPPED    = 3'd2;
    localparam logic [2:0] ST_REL_WAITER = 3'd3;
    localparam logic [2:0] ST_REL_IDLE   = 3'd4;
    localparam logic [2:0] ST_BAD_CLASS  = 3'd5;

    localparam logic MODE_REQUEST = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [1:0] unit_class;
        logic [1:0] severity;
    } t_in_req;

    typedef struct packed {
        logic [2:0]      status;
        logic [ID_W-1:0] request_id;
        logic [1:0]      request_severity;
        logic [1:0]      class_out;
    } t_out_rsp;

    typedef struct packed {
        logic            push;
        logic            pop;
        logic [ID_W-1:0] id;
        logic [1:0]      sev;
    } t_q_cmd;

    typedef struct packed {
        logic            full;
        logic            nonempty;
        logic [ID_W-1:0] head_id;
        logic [1:0]      head_sev;
    } t_q_stat;

endpackage

FILE: sv/ppd_queue.sv
module ppd_queue #(
    parameter int DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ppd_pkg::t_q_cmd  i_cmd,
    output ppd_pkg::t_q_stat o_stat
);
    import ppd_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic [ID_W-1:0] r_id  [DEPTH];
    logic [1:0]      r_sev [DEPTH];
    logic [ID_W-1:0] n_id  [DEPTH];
    logic [1:0]      n_sev [DEPTH];
    logic [DEPTH-1:0] ge;

    // entries that stay ahead of a new request form a prefix of the chain
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            ge[i] = (CW'(i) < r_count) && (r_sev[i] >= i_cmd.sev);
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            always_comb begin
                n_id[g]  = r_id[g];
                n_sev[g] = r_sev[g];
                if (i_cmd.push && !ge[g]) begin
                    if (g == 0) begin
                        n_id[g]  = i_cmd.id;
                        n_sev[g] = i_cmd.sev;
                    end else if (ge[(g == 0) ? 0 : g-1]) begin
                        n_id[g]  = i_cmd.id;
                        n_sev[g] = i_cmd.sev;
                    end else begin
                        n_id[g]  = r_id[(g == 0) ? 0 : g-1];
                        n_sev[g] = r_sev[(g == 0) ? 0 : g-1];
                    end
                end else if (i_cmd.pop && (g < DEPTH-1)) begin
                    n_id[g]  = r_id[(g < DEPTH-1) ? g+1 : g];
                    n_sev[g] = r_sev[(g < DEPTH-1) ? g+1 : g];
                end
            end

            always_ff @(posedge i_clk) begin
                r_id[g]  <= n_id[g];
                r_sev[g] <= n_sev[g];
            end
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (i_cmd.push) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_stat.full     = (r_count == CW'(DEPTH));
    assign o_stat.nonempty = (r_count != '0);
    assign o_stat.head_id  = r_id[0];
    assign o_stat.head_sev = r_sev[0];

endmodule

FILE: sv/pooled_priority_dispatcher_top.sv
// channel   valid        stall        payload
// request   i_in_valid   o_in_stall   i_in_req  (mode, unit_class, severity)
// result    o_out_valid  i_out_stall  o_out_rsp (status, request_id, request_severity,
//                                               class_out)
// config    i_cfg_we     -            i_cfg_addr, i_cfg_wdata
//
// one request per cycle while the result side does not stall; each result passes through
// the input register, then the result register, decision made in one pass between them
// synchronous active-low reset: free counts to 2, queues empty, id counter to zero
// a stalled result holds the result register; the input register then stalls too
module pooled_priority_dispatcher_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int NUM_CLASSES = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ppd_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ppd_pkg::t_out_rsp o_out_rsp,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_addr,
    input  logic [3:0]        i_cfg_wdata
);
    import ppd_pkg::*;

    logic            r_in_valid;
    logic            n_in_valid;
    t_in_req         r_in;
    logic            r_out_valid;
    t_out_rsp        r_out;
    t_out_rsp        n_out;
    logic [ID_W-1:0] r_next_id;
    logic [ID_W-1:0] n_next_id;
    logic [3:0]      r_free [NUM_CLASSES];

    logic            out_free;
    logic            go;
    logic            in_load;
    logic [NUM_CLASSES-1:0] sel;
    logic            bad;
    logic [1:0]      sev_eff;
    logic [ID_W-1:0] id_new;
    logic [3:0]      free_sel;
    logic [3:0]      free_inc;
    logic [3:0]      n_free_sel;
    logic            full_sel;
    logic            nonempty_sel;
    logic [ID_W-1:0] head_id_sel;
    logic [1:0]      head_sev_sel;
    logic            do_push;
    logic            do_pop;
    t_q_cmd          q_cmd  [NUM_CLASSES];
    t_q_stat         q_stat [NUM_CLASSES];

    assign out_free   = !r_out_valid || !i_out_stall;
    assign go         = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_load    = i_in_valid && !o_in_stall;
    assign n_in_valid = in_load ? 1'b1 : (go ? 1'b0 : r_in_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
        if (in_load) begin
            r_in <= i_in_req;
        end
    end

    // class select and per-class state muxing
    always_comb begin
        free_sel     = '0;
        full_sel     = 1'b0;
        nonempty_sel = 1'b0;
        head_id_sel  = '0;
        head_sev_sel = '0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            sel[c] = (32'(r_in.unit_class) == 32'(c));
            if (sel[c]) begin
                free_sel     = r_free[c];
                full_sel     = q_stat[c].full;
                nonempty_sel = q_stat[c].nonempty;
                head_id_sel  = q_stat[c].head_id;
                head_sev_sel = q_stat[c].head_sev;
            end
        end
    end

    assign bad      = (32'(r_in.unit_class) >= 32'(NUM_CLASSES));
    assign sev_eff  = (r_in.severity == 2'd0) ? 2'd1 : r_in.severity;
    assign id_new   = r_next_id + ID_W'(1);
    assign free_inc = (free_sel == FREE_MAX) ? FREE_MAX : free_sel + 4'd1;

    always_comb begin
        do_push    = 1'b0;
        do_pop     = 1'b0;
        n_free_sel = free_sel;
        n_next_id  = r_next_id;
        n_out.status           = ST_BAD_CLASS;
        n_out.request_id       = '0;
        n_out.request_severity = '0;
        n_out.class_out        = r_in.unit_class;
        if (!bad) begin
            if (r_in.mode == MODE_REQUEST) begin
                n_next_id              = id_new;
                n_out.request_id       = id_new;
                n_out.request_severity = sev_eff;
                if (free_sel != 4'd0) begin
                    n_free_sel   = free_sel - 4'd1;
                    n_out.status = ST_DISPATCHED;
                end else if (!full_sel) begin
                    do_push      = 1'b1;
                    n_out.status = ST_QUEUED;
                end else begin
                    n_out.status = ST_DROPPED;
                end
            end else if (nonempty_sel) begin
                // count after the release is never zero, so a waiter always goes
                do_pop                 = 1'b1;
                n_free_sel             = free_inc - 4'd1;
                n_out.status           = ST_REL_WAITER;
                n_out.request_id       = head_id_sel;
                n_out.request_severity = head_sev_sel;
            end else begin
                n_free_sel   = free_inc;
                n_out.status = ST_REL_IDLE;
            end
        end
    end

    genvar gc;
    generate
        for (gc = 0; gc < NUM_CLASSES; gc++) begin : g_class
            always_comb begin
                q_cmd[gc].push = go && sel[gc] && do_push;
                q_cmd[gc].pop  = go && sel[gc] && do_pop;
                q_cmd[gc].id   = id_new;
                q_cmd[gc].sev  = sev_eff;
            end

            ppd_queue #(
                .DEPTH (QUEUE_DEPTH)
            ) u_queue (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (q_cmd[gc]),
                .o_stat  (q_stat[gc])
            );

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_free[gc] <= DEFAULT_POOL;
                end else if (i_cfg_we && (32'(i_cfg_addr) == 32'(gc))
                             && (gc < NUM_POOL_REGS)) begin
                    r_free[gc] <= i_cfg_wdata;
                end else if (go && sel[gc]) begin
                    r_free[gc] <= n_free_sel;
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_next_id   <= '0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (go) begin
                r_next_id <= n_next_id;
            end
        end
        if (go) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import ppd_pkg::*;

    localparam int QDEPTH = 16;
    localparam int NCLASS = 3;

    localparam logic [1:0] REG_POOL_CLASS0 = 2'd0;
    localparam logic [1:0] REG_POOL_CLASS1 = 2'd1;
    localparam logic [1:0] REG_POOL_CLASS2 = 2'd2;
    localparam logic [1:0] REG_UNUSED      = 2'd3;

    localparam logic [1:0] CLASS_BAD = 2'd3;

    localparam int PHASES    = 6;
    localparam int PHASE_LEN = 225;

    typedef enum logic [1:0] {STEP_ITEM, STEP_REG} t_step_kind;

    typedef struct packed {
        t_step_kind kind;
        logic [15:0] reps;
        t_in_req    req;
        logic [1:0] reg_idx;
        logic [3:0] reg_val;
        logic       typed;
        t_out_rsp   rsp;
    } t_step;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    t_in_req  in_req;
    logic     out_valid;
    logic     out_stall = 1'b0;
    t_out_rsp out_rsp;
    logic     cfg_we;
    logic [1:0] cfg_addr;
    logic [3:0] cfg_wdata;

    // predicted block state
    logic [3:0]      units_left[NCLASS];
    logic [ID_W-1:0] wait_id[NCLASS][QDEPTH];
    logic [1:0]      wait_sev[NCLASS][QDEPTH];
    int              wait_len[NCLASS];
    logic [ID_W-1:0] id_ctr;

    t_out_rsp awaited_rsps[$];
    t_step    opening_steps[$];
    int       fail_count = 0;
    int       send_idle_pct = 30;
    int       stall_pct = 30;
    int       stall_left = 0;

    pooled_priority_dispatcher_top #(
        .QUEUE_DEPTH(QDEPTH),
        .NUM_CLASSES(NCLASS)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_req   (in_req),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_rsp  (out_rsp),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_wdata(cfg_wdata)
    );

    always #2 clk = ~clk;

    function automatic int idle_span(input int pct);
        if ($urandom_range(0, 99) >= pct) begin
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(8, 30);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic t_out_rsp predict_dispatch(input t_in_req r);
        t_out_rsp   rsp;
        int         c;
        int         pos;
        int         i;
        logic [1:0] sev;
        rsp = '0;
        rsp.class_out = r.unit_class;
        c = r.unit_class;
        sev = (r.severity == 2'd0) ? 2'd1 : r.severity;
        if (c >= NCLASS) begin
            rsp.status = ST_BAD_CLASS;
            return rsp;
        end
        if (r.mode == MODE_REQUEST) begin
            id_ctr = id_ctr + 1'b1;
            rsp.request_id = id_ctr;
            rsp.request_severity = sev;
            if (units_left[c] != 4'd0) begin
                units_left[c] = units_left[c] - 1'b1;
                rsp.status = ST_DISPATCHED;
            end else if (wait_len[c] < QDEPTH) begin
                // behind every waiter of equal or higher severity
                pos = 0;
                while (pos < wait_len[c] && wait_sev[c][pos] >= sev) pos++;
                for (i = wait_len[c]; i > pos; i--) begin
                    wait_id[c][i] = wait_id[c][i-1];
                    wait_sev[c][i] = wait_sev[c][i-1];
                end
                wait_id[c][pos] = id_ctr;
                wait_sev[c][pos] = sev;
                wait_len[c] = wait_len[c] + 1;
                rsp.status = ST_QUEUED;
            end else begin
                rsp.status = ST_DROPPED;
            end
            return rsp;
        end
        if (units_left[c] != FREE_MAX) begin
            units_left[c] = units_left[c] + 1'b1;
        end
        if (wait_len[c] > 0 && units_left[c] != 4'd0) begin
            rsp.status = ST_REL_WAITER;
            rsp.request_id = wait_id[c][0];
            rsp.request_severity = wait_sev[c][0];
            for (i = 1; i < wait_len[c]; i++) begin
                wait_id[c][i-1] = wait_id[c][i];
                wait_sev[c][i-1] = wait_sev[c][i];
            end
            wait_len[c] = wait_len[c] - 1;
            units_left[c] = units_left[c] - 1'b1;
        end else begin
            rsp.status = ST_REL_IDLE;
        end
        return rsp;
    endfunction

    function automatic t_in_req random_request(input int req_pct);
        t_in_req r;
        r.mode = ($urandom_range(0, 99) < req_pct) ? MODE_REQUEST : MODE_RELEASE;
        r.unit_class = ($urandom_range(0, 19) == 0) ? CLASS_BAD : 2'($urandom_range(0, 2));
        r.severity = 2'($urandom_range(0, 3));
        return r;
    endfunction

    function automatic t_step plain_step(input logic mode, input logic [1:0] cls,
                                         input logic [1:0] sev, input int reps);
        t_step s;
        s = '0;
        s.kind = STEP_ITEM;
        s.reps = reps[15:0];
        s.req.mode = mode;
        s.req.unit_class = cls;
        s.req.severity = sev;
        return s;
    endfunction

    function automatic t_step typed_step(input logic mode, input logic [1:0] cls,
                                         input logic [1:0] sev, input logic [2:0] st,
                                         input logic [ID_W-1:0] id, input logic [1:0] rsev);
        t_step s;
        s = plain_step(mode, cls, sev, 1);
        s.typed = 1'b1;
        s.rsp.status = st;
        s.rsp.request_id = id;
        s.rsp.request_severity = rsev;
        s.rsp.class_out = cls;
        return s;
    endfunction

    function automatic t_step reg_step(input logic [1:0] idx, input logic [3:0] val);
        t_step s;
        s = '0;
        s.kind = STEP_REG;
        s.reg_idx = idx;
        s.reg_val = val;
        return s;
    endfunction

    task automatic offer_request(input t_in_req r, input logic typed, input t_out_rsp typed_rsp);
        int       gap;
        t_out_rsp predicted;
        gap = idle_span(send_idle_pct);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req <= r;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predicted = predict_dispatch(r);
        awaited_rsps.push_back(typed ? typed_rsp : predicted);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (awaited_rsps.size() != 0) @(posedge clk);
        // input and result registers
        repeat (2) @(posedge clk);
    endtask

    task automatic write_pool(input logic [1:0] idx, input logic [3:0] val);
        wait_for_results();
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx < NUM_POOL_REGS && idx < NCLASS) begin
            units_left[idx] = val;
        end
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
            fail_count++;
        end
    endtask

    // result side back-pressure, runs of random length
    always @(posedge clk) begin : stall_gen
        int len;
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else begin
            len = idle_span(stall_pct);
            if (len != 0) begin
                out_stall <= 1'b1;
                stall_left <= len - 1;
            end else begin
                out_stall <= 1'b0;
                stall_left <= $urandom_range(0, 4);
            end
        end
    end

    always @(posedge clk) begin : result_check
        t_out_rsp want;
        if (rst_n && out_valid && !out_stall) begin
            if (awaited_rsps.size() == 0) begin
                $display("%0t: result with no request pending: %p", $time, out_rsp);
                fail_count++;
            end else begin
                want = awaited_rsps.pop_front();
                check_field("status", want.status, out_rsp.status);
                check_field("request_id", want.request_id, out_rsp.request_id);
                check_field("request_severity", want.request_severity,
                            out_rsp.request_severity);
                check_field("class_out", want.class_out, out_rsp.class_out);
            end
        end
    end

    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int      k;
        int      c;
        int      n;
        int      phase;
        int      req_pct;
        t_step   s;
        t_in_req r;
        logic [3:0] pool;

        rst_n = 1'b0;
        in_valid = 1'b0;
        in_req = '0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        for (c = 0; c < NCLASS; c++) begin
            units_left[c] = DEFAULT_POOL;
            wait_len[c] = 0;
        end
        id_ctr = '0;

        // two free units per class out of reset
        opening_steps.push_back(typed_step(MODE_REQUEST, 2'd0, 2'd3, ST_DISPATCHED, 16'd1, 2'd3));
        // severity zero counts as one
        opening_steps.push_back(typed_step(MODE_REQUEST, 2'd0, 2'd0, ST_DISPATCHED, 16'd2, 2'd1));
        opening_steps.push_back(typed_step(MODE_REQUEST, 2'd0, 2'd1, ST_QUEUED, 16'd3, 2'd1));
        opening_steps.push_back(typed_step(MODE_REQUEST, 2'd0, 2'd2, ST_QUEUED, 16'd4, 2'd2));
        opening_steps.push_back(typed_step(MODE_REQUEST, 2'd0, 2'd2, ST_QUEUED, 16'd5, 2'd2));
        opening_steps.push_back(typed_step(MODE_REQUEST, 2'd0, 2'd3, ST_QUEUED, 16'd6, 2'd3));
        // waiters leave by severity, then by arrival
        opening_steps.push_back(typed_step(MODE_RELEASE, 2'd0, 2'd0, ST_REL_WAITER, 16'd6, 2'd3));
        opening_steps.push_back(typed_step(MODE_RELEASE, 2'd0, 2'd0, ST_REL_WAITER, 16'd4, 2'd2));
        opening_steps.push_back(typed_step(MODE_RELEASE, 2'd0, 2'd0, ST_REL_WAITER, 16'd5, 2'd2));
        opening_steps.push_back(typed_step(MODE_RELEASE, 2'd0, 2'd0, ST_REL_WAITER, 16'd3, 2'd1));
        opening_steps.push_back(typed_step(MODE_RELEASE, 2'd0, 2'd0, ST_REL_IDLE, 16'd0, 2'd0));
        opening_steps.push_back(typed_step(MODE_REQUEST, CLASS_BAD, 2'd3, ST_BAD_CLASS, 16'd0, 2'd0));
        opening_steps.push_back(typed_step(MODE_RELEASE, CLASS_BAD, 2'd0, ST_BAD_CLASS, 16'd0, 2'd0));
        // release with the free count already at its ceiling
        opening_steps.push_back(reg_step(REG_POOL_CLASS1, FREE_MAX));
        opening_steps.push_back(typed_step(MODE_RELEASE, 2'd1, 2'd3, ST_REL_IDLE, 16'd0, 2'd0));
        // fill class two, then overflow it
        opening_steps.push_back(reg_step(REG_POOL_CLASS2, 4'd0));
        opening_steps.push_back(plain_step(MODE_REQUEST, 2'd2, 2'd1, QDEPTH));
        opening_steps.push_back(typed_step(MODE_REQUEST, 2'd2, 2'd3, ST_DROPPED, 16'd23, 2'd3));
        // a free unit next to waiters goes to the newcomer
        opening_steps.push_back(reg_step(REG_POOL_CLASS2, 4'd1));
        opening_steps.push_back(typed_step(MODE_REQUEST, 2'd2, 2'd2, ST_DISPATCHED, 16'd24, 2'd2));
        opening_steps.push_back(typed_step(MODE_RELEASE, 2'd2, 2'd0, ST_REL_WAITER, 16'd7, 2'd1));
        opening_steps.push_back(reg_step(REG_UNUSED, 4'd9));
        opening_steps.push_back(typed_step(MODE_REQUEST, 2'd2, 2'd1, ST_QUEUED, 16'd25, 2'd1));
        // fresh queue on class one, a late urgent request jumps ahead
        opening_steps.push_back(reg_step(REG_POOL_CLASS1, 4'd0));
        opening_steps.push_back(plain_step(MODE_REQUEST, 2'd1, 2'd2, 4));
        opening_steps.push_back(typed_step(MODE_REQUEST, 2'd1, 2'd3, ST_QUEUED, 16'd30, 2'd3));
        opening_steps.push_back(plain_step(MODE_RELEASE, 2'd1, 2'd1, 3));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < opening_steps.size(); k++) begin
            s = opening_steps[k];
            case (s.kind)
                STEP_REG: begin
                    write_pool(s.reg_idx, s.reg_val);
                end
                default: begin
                    repeat (s.reps) offer_request(s.req, s.typed, s.rsp);
                end
            endcase
        end

        for (phase = 0; phase < PHASES; phase++) begin
            for (c = 0; c < NCLASS; c++) begin
                case (phase)
                    0: pool = 4'd0;
                    1: pool = FREE_MAX;
                    default: pool = ($urandom_range(0, 9) == 0) ? FREE_MAX
                                                                : 4'($urandom_range(0, 3));
                endcase
                write_pool(REG_POOL_CLASS0 + 2'(c), pool);
            end
            if (phase % 2 == 1) begin
                write_pool(REG_UNUSED, 4'($urandom_range(0, 15)));
            end
            case (phase)
                0: begin send_idle_pct = 20; stall_pct = 30; req_pct = 70; end
                1: begin send_idle_pct = 40; stall_pct = 10; req_pct = 50; end
                2: begin send_idle_pct = 0;  stall_pct = 0;  req_pct = 60; end
                3: begin send_idle_pct = 30; stall_pct = 50; req_pct = 55; end
                4: begin send_idle_pct = 10; stall_pct = 60; req_pct = 65; end
                default: begin send_idle_pct = 50; stall_pct = 20; req_pct = 50; end
            endcase
            for (n = 0; n < PHASE_LEN; n++) begin
                // hold off until the block has answered everything
                if (phase == 3 && n == PHASE_LEN / 2) begin
                    wait_for_results();
                end
                r = random_request(req_pct);
                offer_request(r, 1'b0, '0);
            end
        end

        wait_for_results();
        repeat (6) @(posedge clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
